// ===== hdl/d8ss_pkg.sv =====
// ----------------------------------------------------------------------------
// d8ss_pkg
// Shared types, codes and constants of the steepest-slope stencil unit.
// ----------------------------------------------------------------------------
package d8ss_pkg;

  // fixed field widths
  localparam int ELEV_BITS  = 24;
  localparam int KEY_W      = ELEV_BITS + 16;
  localparam int LINE_NUM_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W     = 6;

  // item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MODE   = 2'd3;

  // output units
  localparam logic [2:0] UNIT_TAN  = 3'd0;
  localparam logic [2:0] UNIT_RAD  = 3'd1;
  localparam logic [2:0] UNIT_DEG  = 3'd2;
  localparam logic [2:0] UNIT_SINE = 3'd3;
  localparam logic [2:0] UNIT_PCT  = 3'd4;

  // multiplier operand selects
  localparam logic [2:0] MUL_KD  = 3'd0;
  localparam logic [2:0] MUL_HI  = 3'd1;
  localparam logic [2:0] MUL_LO  = 3'd2;
  localparam logic [2:0] MUL_PCT = 3'd3;
  localparam logic [2:0] MUL_DEG = 3'd4;
  localparam logic [2:0] MUL_SQ  = 3'd5;

  // result selects
  localparam logic [2:0] RES_T   = 3'd0;
  localparam logic [2:0] RES_PCT = 3'd1;
  localparam logic [2:0] RES_RAD = 3'd2;
  localparam logic [2:0] RES_DEG = 3'd3;
  localparam logic [2:0] RES_DIV = 3'd4;

  // arithmetic constants
  localparam logic [15:0] W_DIAG      = 16'd46341;
  localparam logic [21:0] DEG_PER_RAD = 22'd3754936;
  localparam logic [6:0]  PCT_SCALE   = 7'd100;

  // iteration counts
  localparam logic [STEP_W-1:0] CORDIC_LAST = 6'd16;
  localparam logic [STEP_W-1:0] SQRT_LAST   = 6'd31;
  localparam logic [STEP_W-1:0] DIV_LAST    = 6'd47;

  typedef struct packed {
    logic                        mode;
    logic signed [ELEV_BITS-1:0] elevation;
  } sample_t;

  typedef struct packed {
    logic [31:0] slope;
    logic        last;
  } result_t;

  typedef struct packed {
    logic              cfg_write;
    logic              take;
    logic              restart;
    logic              read;
    logic              push;
    logic              diff;
    logic              key;
    logic              acc;
    logic              tval;
    logic              mul_en;
    logic [2:0]        mul_sel;
    logic              res_load;
    logic [2:0]        res_sel;
    logic              cordic_init;
    logic              cordic_step;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic       mode;
    logic       grid_done;
    logic       pend_zero;
    logic       centre_ready;
    logic [2:0] unit;
    logic       out_free;
  } status_t;

  // atan(2^-i) in Q16.16
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30386;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/d8ss_ctrl.sv =====
// ----------------------------------------------------------------------------
// d8ss_ctrl
// Sequencer of the stencil unit: walks each item through the datapath steps.
// ----------------------------------------------------------------------------
module d8ss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  d8ss_pkg::status_t st,
  output d8ss_pkg::cmd_t    cmd
);
  import d8ss_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_READ  = 5'd2;
  localparam logic [4:0] S_PUSH  = 5'd3;
  localparam logic [4:0] S_DIFF  = 5'd4;
  localparam logic [4:0] S_KD    = 5'd5;
  localparam logic [4:0] S_KEY   = 5'd6;
  localparam logic [4:0] S_HI    = 5'd7;
  localparam logic [4:0] S_LO    = 5'd8;
  localparam logic [4:0] S_TVAL  = 5'd9;
  localparam logic [4:0] S_UNIT  = 5'd10;
  localparam logic [4:0] S_PCT   = 5'd11;
  localparam logic [4:0] S_CORD  = 5'd12;
  localparam logic [4:0] S_CEND  = 5'd13;
  localparam logic [4:0] S_DEG   = 5'd14;
  localparam logic [4:0] S_SQI   = 5'd15;
  localparam logic [4:0] S_SQ    = 5'd16;
  localparam logic [4:0] S_DVI   = 5'd17;
  localparam logic [4:0] S_DV    = 5'd18;
  localparam logic [4:0] S_DVE   = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  logic [4:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              iter, iter_next;

  // handshakes only in idle
  assign sample_stall = (state != S_IDLE);
  assign cfg_ready    = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      iter  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      iter  <= iter_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    iter_next  = iter;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.cfg_write = cfg_valid;
        if (sample_valid) begin
          cmd.take   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        iter_next = 1'b0;
        if (st.mode == MODE_DRAIN) begin
          if (!st.grid_done || st.pend_zero) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_READ;
          end
        end else begin
          cmd.restart = st.grid_done;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (st.centre_ready) begin
          state_next = S_DIFF;
        end else if (st.mode == MODE_DRAIN && !iter) begin
          iter_next  = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_KD;
      end
      S_KD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KD;
        state_next  = S_KEY;
      end
      S_KEY: begin
        cmd.key    = 1'b1;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI;
        state_next  = S_LO;
      end
      S_LO: begin
        cmd.acc     = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
        state_next  = S_TVAL;
      end
      S_TVAL: begin
        cmd.tval   = 1'b1;
        state_next = S_UNIT;
      end
      S_UNIT: begin
        unique case (st.unit)
          UNIT_RAD, UNIT_DEG: begin
            cmd.cordic_init = 1'b1;
            cnt_next        = '0;
            state_next      = S_CORD;
          end
          UNIT_SINE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SQ;
            state_next  = S_SQI;
          end
          UNIT_PCT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PCT;
            state_next  = S_PCT;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_T;
            state_next   = S_DONE;
          end
        endcase
      end
      S_PCT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_PCT;
        state_next   = S_DONE;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        cnt_next        = cnt + 1'b1;
        if (cnt == CORDIC_LAST) begin
          state_next = S_CEND;
        end
      end
      S_CEND: begin
        if (st.unit == UNIT_DEG) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_DEG;
          state_next  = S_DEG;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RAD;
          state_next   = S_DONE;
        end
      end
      S_DEG: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_DEG;
        state_next   = S_DONE;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_SQ;
      end
      S_SQ: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == SQRT_LAST) begin
          state_next = S_DVI;
        end
      end
      S_DVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_DVE;
        end
      end
      S_DVE: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_DIV;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.step = cnt;
  end

endmodule

// ===== hdl/d8ss_datapath.sv =====
// ----------------------------------------------------------------------------
// d8ss_datapath
// Line stores, 3x3 window, shared multiplier, CORDIC, square root and divider.
// ----------------------------------------------------------------------------
module d8ss_datapath #(
  parameter int MAX_LINE = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  d8ss_pkg::sample_t                   sample,
  input  logic [d8ss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [d8ss_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  d8ss_pkg::cmd_t                      cmd,
  output d8ss_pkg::status_t                   st,
  output logic                                result_valid,
  input  logic                                result_stall,
  output d8ss_pkg::result_t                   result
);
  import d8ss_pkg::*;

  localparam int AW = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int PW = $clog2(MAX_LINE + 2);

  // configuration
  logic [12:0] line_length;
  logic [15:0] line_count;
  logic [23:0] inv_cell;
  logic [2:0]  unit_mode;

  // position state
  logic [AW-1:0]         pos;
  logic [LINE_NUM_W-1:0] line_num;
  logic [PW-1:0]         pend;

  // latched item
  logic                        item_mode;
  logic signed [ELEV_BITS-1:0] item_elev;

  // line stores and window
  logic signed [ELEV_BITS-1:0] mem_a [MAX_LINE];
  logic signed [ELEV_BITS-1:0] mem_b [MAX_LINE];
  logic signed [ELEV_BITS-1:0] rd_a, rd_b;
  logic signed [ELEV_BITS-1:0] win [9];

  // edge flags of the current centre
  logic col0_ok, col2_ok, row0_ok, row2_ok, last_flag;

  // arithmetic registers
  logic [ELEV_BITS-1:0] ds, dd;
  logic [KEY_W-1:0]     key, acc;
  logic [63:0]          prod;
  logic [31:0]          tval, res_val;
  logic signed [35:0]   cx, cy;
  logic signed [18:0]   cz;
  logic [63:0]          sq_n, sq_res;
  logic [47:0]          dv_q;
  logic [33:0]          dv_rem;

  // combinational helpers
  logic [LW-1:0]         eff_len, pos_plus, xc;
  logic [15:0]           eff_cnt;
  logic [LINE_NUM_W-1:0] yc;
  logic                  centre_ready, grid_done, pos_wrap;
  logic signed [ELEV_BITS:0] dif [9];
  logic [ELEV_BITS-1:0]  drop [9];
  logic [8:0]            nb_ok;
  logic [ELEV_BITS-1:0]  ds_c, dd_c, s0, s1, d0, d1;
  logic signed [ELEV_BITS-1:0] col_bot;
  logic [31:0]           mul_a, mul_b;
  logic [KEY_W-1:0]      ks;
  logic [KEY_W:0]        tsum;
  logic [16:0]           rad;
  logic [4:0]            ci;
  logic [35:0]           ay;
  logic [5:0]            sq_sh;
  logic [63:0]           sq_bit, sq_try;
  logic [33:0]           dv_sh;

  // effective geometry
  always_comb begin
    if (line_length == 13'd0) begin
      eff_len = LW'(1);
    end else if (32'(line_length) > 32'(MAX_LINE)) begin
      eff_len = LW'(MAX_LINE);
    end else begin
      eff_len = LW'(line_length);
    end
    eff_cnt = (line_count == 16'd0) ? 16'd1 : line_count;
  end

  // centre position of the window after this push
  always_comb begin
    pos_plus     = LW'(pos) + LW'(1);
    pos_wrap     = (pos_plus >= eff_len);
    grid_done    = (line_num >= LINE_NUM_W'(eff_cnt));
    centre_ready = (line_num >= LINE_NUM_W'(2)) ||
                   (line_num == LINE_NUM_W'(1) && pos != '0);
    if (pos == '0) begin
      xc = eff_len - LW'(1);
      yc = line_num - LINE_NUM_W'(2);
    end else begin
      xc = LW'(pos) - LW'(1);
      yc = line_num - LINE_NUM_W'(1);
    end
    col_bot = (item_mode == MODE_DRAIN) ? '0 : item_elev;
  end

  // status to the sequencer
  always_comb begin
    st.mode         = item_mode;
    st.grid_done    = grid_done;
    st.pend_zero    = (pend == '0);
    st.centre_ready = centre_ready;
    st.unit         = unit_mode;
    st.out_free     = !result_valid || !result_stall;
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= 13'd4096;
      line_count  <= 16'd1;
      inv_cell    <= 24'd65536;
      unit_mode   <= UNIT_TAN;
      pos         <= '0;
      line_num    <= '0;
      pend        <= '0;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        CFG_LINE_LENGTH: begin
          line_length <= cfg_data[12:0];
          pos         <= '0;
          line_num    <= '0;
          pend        <= '0;
        end
        CFG_LINE_COUNT: begin
          line_count <= cfg_data[15:0];
          pos        <= '0;
          line_num   <= '0;
          pend       <= '0;
        end
        CFG_INV_CELL:  inv_cell  <= cfg_data[23:0];
        CFG_UNIT_MODE: unit_mode <= cfg_data[2:0];
      endcase
    end else if (cmd.restart) begin
      pos      <= '0;
      line_num <= '0;
      pend     <= '0;
    end else if (cmd.push) begin
      if (pos_wrap) begin
        pos      <= '0;
        line_num <= line_num + LINE_NUM_W'(1);
      end else begin
        pos <= AW'(pos_plus);
      end
      if (item_mode == MODE_SAMPLE) begin
        if (!centre_ready) begin
          pend <= pend + PW'(1);
        end
      end else if (centre_ready) begin
        pend <= pend - PW'(1);
        // last pending result: start over
        if (pend == PW'(1)) begin
          pos      <= '0;
          line_num <= '0;
        end
      end
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_mode <= sample.mode;
      item_elev <= sample.elevation;
    end
  end

  // line store a
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_a <= mem_a[pos];
    end
    if (cmd.push && item_mode == MODE_SAMPLE) begin
      mem_a[pos] <= item_elev;
    end
  end

  // line store b takes the line leaving store a
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_b <= mem_b[pos];
    end
    if (cmd.push && item_mode == MODE_SAMPLE) begin
      mem_b[pos] <= rd_a;
    end
  end

  // window shift and edge flags
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int k = 0; k < 6; k++) begin
        win[k] <= win[k+3];
      end
      win[6]    <= rd_b;
      win[7]    <= rd_a;
      win[8]    <= col_bot;
      col0_ok   <= (xc != '0);
      col2_ok   <= ({1'b0, xc} + (LW+1)'(1)) < {1'b0, eff_len};
      row0_ok   <= (yc != '0);
      row2_ok   <= ({1'b0, yc} + (LINE_NUM_W+1)'(1)) < (LINE_NUM_W+1)'(eff_cnt);
      last_flag <= (yc == LINE_NUM_W'(eff_cnt) - LINE_NUM_W'(1)) &&
                   (xc == eff_len - LW'(1));
    end
  end

  // drops to lower neighbours inside the grid
  always_comb begin
    nb_ok    = 9'h1FF;
    nb_ok[4] = 1'b0;
    if (!col0_ok) nb_ok[2:0] = 3'b000;
    if (!col2_ok) nb_ok[8:6] = 3'b000;
    if (!row0_ok) begin
      nb_ok[0] = 1'b0;
      nb_ok[3] = 1'b0;
      nb_ok[6] = 1'b0;
    end
    if (!row2_ok) begin
      nb_ok[2] = 1'b0;
      nb_ok[5] = 1'b0;
      nb_ok[8] = 1'b0;
    end
    for (int k = 0; k < 9; k++) begin
      dif[k]  = {win[4][ELEV_BITS-1], win[4]} - {win[k][ELEV_BITS-1], win[k]};
      drop[k] = (nb_ok[k] && win[k] < win[4]) ? dif[k][ELEV_BITS-1:0] : '0;
    end
    s0   = (drop[1] > drop[3]) ? drop[1] : drop[3];
    s1   = (drop[5] > drop[7]) ? drop[5] : drop[7];
    ds_c = (s0 > s1) ? s0 : s1;
    d0   = (drop[0] > drop[2]) ? drop[0] : drop[2];
    d1   = (drop[6] > drop[8]) ? drop[6] : drop[8];
    dd_c = (d0 > d1) ? d0 : d1;
  end

  // shared multiplier operands
  always_comb begin
    rad = (tval == 32'd0 || cz[18]) ? 17'd0 : cz[16:0];
    unique case (cmd.mul_sel)
      MUL_KD: begin
        mul_a = 32'(dd);
        mul_b = 32'(W_DIAG);
      end
      MUL_HI: begin
        mul_a = 32'(key[KEY_W-1:24]);
        mul_b = 32'(inv_cell);
      end
      MUL_LO: begin
        mul_a = 32'(key[23:0]);
        mul_b = 32'(inv_cell);
      end
      MUL_PCT: begin
        mul_a = tval;
        mul_b = 32'(PCT_SCALE);
      end
      MUL_DEG: begin
        mul_a = 32'(rad);
        mul_b = 32'(DEG_PER_RAD);
      end
      MUL_SQ: begin
        mul_a = tval;
        mul_b = tval;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    ks   = {ds, 16'd0};
    tsum = {1'b0, acc} + (KEY_W+1)'(prod[47:24]);
  end

  // slope tangent chain
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      ds <= ds_c;
      dd <= dd_c;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.key) begin
      key <= (ks > prod[KEY_W-1:0]) ? ks : prod[KEY_W-1:0];
    end
    if (cmd.acc) begin
      acc <= prod[KEY_W-1:0];
    end
    if (cmd.tval) begin
      tval <= (|tsum[KEY_W:32]) ? 32'hFFFF_FFFF : tsum[31:0];
    end
  end

  // cordic vectoring, one step a cycle
  always_comb begin
    ci = cmd.step[4:0];
    ay = cy[35] ? 36'(-cy) : 36'(cy);
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx <= 36'sd65536;
      cy <= $signed({4'b0000, tval});
      cz <= '0;
    end else if (cmd.cordic_step) begin
      cx <= cx + $signed(ay >> ci);
      if (!cy[35]) begin
        cy <= cy - (cx >>> ci);
        cz <= cz + $signed({2'b00, atan_q16(ci)});
      end else begin
        cy <= cy + (cx >>> ci);
        cz <= cz - $signed({2'b00, atan_q16(ci)});
      end
    end
  end

  // square root, one result bit a cycle
  always_comb begin
    sq_sh  = 6'd62 - {cmd.step[4:0], 1'b0};
    sq_bit = 64'd1 << sq_sh;
    sq_try = sq_res + sq_bit;
    dv_sh  = {dv_rem[32:0], dv_q[47]};
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_n   <= prod + 64'h0000_0001_0000_0000;
      sq_res <= '0;
    end else if (cmd.sqrt_step) begin
      if (sq_n >= sq_try) begin
        sq_n   <= sq_n - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dv_q   <= {tval, 16'd0};
      dv_rem <= '0;
    end else if (cmd.div_step) begin
      if (dv_sh >= {1'b0, sq_res[32:0]}) begin
        dv_rem <= dv_sh - {1'b0, sq_res[32:0]};
        dv_q   <= {dv_q[46:0], 1'b1};
      end else begin
        dv_rem <= dv_sh;
        dv_q   <= {dv_q[46:0], 1'b0};
      end
    end
  end

  // result select
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_PCT: res_val <= (|prod[63:32]) ? 32'hFFFF_FFFF : prod[31:0];
        RES_RAD: res_val <= 32'(rad);
        RES_DEG: res_val <= prod[47:16];
        RES_DIV: res_val <= dv_q[31:0];
        default: res_val <= tval;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.slope <= res_val;
      result.last  <= last_flag;
    end
  end

endmodule

// ===== hdl/d8_steepest_slope_stencil_unit.sv =====
// ----------------------------------------------------------------------------
// d8_steepest_slope_stencil_unit
// Steepest-descent slope of a raster elevation stream over a 3x3 window.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (valid/stall): one elevation per transfer in scan order,
//   or a drain tick that flushes one pending result after the grid ends.
//   result channel (valid/stall): slope in the selected unit and a last flag.
//   cfg channel (valid/ready): register index and data, taken only when idle.
// Sequencing:
//   One item is in flight at a time. Tangent and percent need only the
//   shared multiplier; radians and degrees add the 17-step CORDIC loop,
//   sine the bit-serial square root and divider. A drain tick may need
//   two window pushes. A sample or drain tick without a result still
//   stalls the input until the sequencer is back in idle.
// The finished result sits in an output register, so the next item is taken
// while it waits; if the receiver still stalls when a second result is ready,
// the sequencer holds and the sample channel stalls.
// Reset clears counters and restores the register defaults. The line stores
// are not cleared: entries outside the grid are never used.
// ----------------------------------------------------------------------------
module d8_steepest_slope_stencil_unit #(
  parameter int MAX_LINE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  d8ss_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output d8ss_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [d8ss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [d8ss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import d8ss_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer
  d8ss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .st           (st),
    .cmd          (cmd)
  );

  // datapath
  d8ss_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== hdl/d8ss_checker.sv =====
// ----------------------------------------------------------------------------
// d8ss_checker
// Port-level checks of the stencil unit, bound to the top level.
// ----------------------------------------------------------------------------
module d8ss_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input logic              result_valid,
  input logic              result_stall,
  input d8ss_pkg::result_t result
);
  import d8ss_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one item at a time: busy after each transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while busy");

  // a new result comes only out of a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared while idle");

  // reset empties the output and frees the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("reset did not clear the block");

endmodule

bind d8_steepest_slope_stencil_unit d8ss_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
